FILE: src/assert_macros.svh
// Assertion macros shared by the RTL. With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FFA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define FFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FFA_ASSERT(lbl, clk, rstn, prop)
`define FFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/ffa_pkg.sv
package ffa_pkg;

  localparam int ADDR_BITS    = 24;
  localparam int HEAP_W       = ADDR_BITS + 1;
  localparam int HEADER_BYTES = 16;
  localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(65536);
  localparam logic [HEAP_W-1:0] HEAP_CAP   = HEAP_W'(1) << ADDR_BITS;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_FULL = 2'd2,
    ST_IGN  = 2'd3
  } status_e;

  typedef struct packed {
    logic                 req_type;
    logic [ADDR_BITS-1:0] alloc_size;
    logic [ADDR_BITS-1:0] free_addr;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [ADDR_BITS-1:0] payload_addr;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WALK, S_A_SPL, S_A_FW, S_A_NW, S_F_PRV, S_F_PCK,
    S_F_NXT, S_F_NCK, S_F_NN, S_F_NNW, S_F_WR, S_RESP
  } state_e;

  typedef enum logic [1:0] {RD_ZERO, RD_RNEXT, RD_WPREV, RD_WNEXT} rd_sel_e;

  typedef enum logic [2:0] {
    WR_INIT, WR_SPLIT, WR_AFIT, WR_LINK_S, WR_LINK_W, WR_W
  } wr_sel_e;

  typedef enum logic [1:0] {W_HIT, W_PMERGE, W_NMERGE} w_sel_e;

  typedef struct packed {
    logic    init;
    logic    accept;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    w_ld;
    w_sel_e  w_sel;
    logic    pop;
    logic    push;
    logic    push_rd;
    logic    resp_ld;
    status_e resp_status;
    logic    resp_addr;
  } cmd_t;

  typedef struct packed {
    logic fit;
    logic match;
    logic rfree;
    logic rnext_nil;
    logic wprev_nil;
    logic wnext_nil;
    logic spare_empty;
    logic free_bad;
    logic req_free;
    logic out_busy;
  } sts_t;

endpackage

FILE: src/ffa_ctrl.sv
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ffa_pkg::sts_t sts_i,
  output ffa_pkg::cmd_t cmd_o
);

  ffa_pkg::state_e  state_q, state_d;
  logic             op_free_q, op_free_d;
  ffa_pkg::status_e st_q, st_d;
  logic             ad_q, ad_d;
  logic             in_fire;

  assign in_ready_o = (state_q == ffa_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ffa_pkg::S_INIT;
      op_free_q <= 1'b0;
      st_q      <= ffa_pkg::ST_OK;
      ad_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_free_q <= op_free_d;
      st_q      <= st_d;
      ad_q      <= ad_d;
    end
  end

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    op_free_d = op_free_q;
    st_d      = st_q;
    ad_d      = ad_q;
    case (state_q)
      ffa_pkg::S_INIT: begin
        cmd_o.init   = 1'b1;
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ffa_pkg::WR_INIT;
        state_d      = ffa_pkg::S_IDLE;
      end
      ffa_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_o.accept = 1'b1;
          op_free_d    = sts_i.req_free;
          if (sts_i.req_free && sts_i.free_bad) begin
            st_d    = ffa_pkg::ST_IGN;
            ad_d    = 1'b0;
            state_d = ffa_pkg::S_RESP;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = ffa_pkg::RD_ZERO;
            state_d      = ffa_pkg::S_WALK;
          end
        end
      end
      ffa_pkg::S_WALK: begin
        if (!op_free_q && sts_i.fit) begin
          cmd_o.w_ld  = 1'b1;
          cmd_o.w_sel = ffa_pkg::W_HIT;
          state_d     = ffa_pkg::S_A_SPL;
        end else if (op_free_q && sts_i.match) begin
          if (sts_i.rfree) begin
            st_d    = ffa_pkg::ST_IGN;
            ad_d    = 1'b0;
            state_d = ffa_pkg::S_RESP;
          end else begin
            cmd_o.w_ld  = 1'b1;
            cmd_o.w_sel = ffa_pkg::W_HIT;
            state_d     = ffa_pkg::S_F_PRV;
          end
        end else if (sts_i.rnext_nil) begin
          st_d    = op_free_q ? ffa_pkg::ST_IGN : ffa_pkg::ST_OOM;
          ad_d    = 1'b0;
          state_d = ffa_pkg::S_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ffa_pkg::RD_RNEXT;
        end
      end
      ffa_pkg::S_A_SPL: begin
        if (sts_i.spare_empty) begin
          st_d    = ffa_pkg::ST_FULL;
          ad_d    = 1'b0;
          state_d = ffa_pkg::S_RESP;
        end else begin
          cmd_o.pop    = 1'b1;
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ffa_pkg::WR_SPLIT;
          cmd_o.rd_en  = !sts_i.wnext_nil;
          cmd_o.rd_sel = ffa_pkg::RD_WNEXT;
          state_d      = ffa_pkg::S_A_FW;
        end
      end
      ffa_pkg::S_A_FW: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ffa_pkg::WR_AFIT;
        st_d         = ffa_pkg::ST_OK;
        ad_d         = 1'b1;
        state_d      = sts_i.wnext_nil ? ffa_pkg::S_RESP : ffa_pkg::S_A_NW;
      end
      ffa_pkg::S_A_NW: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ffa_pkg::WR_LINK_S;
        state_d      = ffa_pkg::S_RESP;
      end
      ffa_pkg::S_F_PRV: begin
        if (sts_i.wprev_nil) begin
          state_d = ffa_pkg::S_F_NXT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ffa_pkg::RD_WPREV;
          state_d      = ffa_pkg::S_F_PCK;
        end
      end
      ffa_pkg::S_F_PCK: begin
        if (sts_i.rfree) begin
          cmd_o.w_ld    = 1'b1;
          cmd_o.w_sel   = ffa_pkg::W_PMERGE;
          cmd_o.push    = 1'b1;
          cmd_o.push_rd = 1'b0;
        end
        state_d = ffa_pkg::S_F_NXT;
      end
      ffa_pkg::S_F_NXT: begin
        if (sts_i.wnext_nil) begin
          state_d = ffa_pkg::S_F_WR;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ffa_pkg::RD_WNEXT;
          state_d      = ffa_pkg::S_F_NCK;
        end
      end
      ffa_pkg::S_F_NCK: begin
        if (sts_i.rfree) begin
          cmd_o.w_ld    = 1'b1;
          cmd_o.w_sel   = ffa_pkg::W_NMERGE;
          cmd_o.push    = 1'b1;
          cmd_o.push_rd = 1'b1;
          state_d       = sts_i.rnext_nil ? ffa_pkg::S_F_WR : ffa_pkg::S_F_NN;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ffa_pkg::WR_LINK_W;
          state_d      = ffa_pkg::S_F_WR;
        end
      end
      ffa_pkg::S_F_NN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ffa_pkg::RD_WNEXT;
        state_d      = ffa_pkg::S_F_NNW;
      end
      ffa_pkg::S_F_NNW: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ffa_pkg::WR_LINK_W;
        state_d      = ffa_pkg::S_F_WR;
      end
      ffa_pkg::S_F_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ffa_pkg::WR_W;
        st_d         = ffa_pkg::ST_OK;
        ad_d         = 1'b0;
        state_d      = ffa_pkg::S_RESP;
      end
      ffa_pkg::S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.resp_ld = 1'b1;
          state_d       = ffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffa_pkg::S_INIT;
      end
    endcase
    cmd_o.resp_status = st_q;
    cmd_o.resp_addr   = ad_q;
    if (cfg_we_i) begin
      state_d = ffa_pkg::S_INIT;
    end
  end

endmodule

FILE: src/ffa_dp.sv
module ffa_dp #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ffa_pkg::HEAP_W-1:0]   cfg_wdata_i,
  input  ffa_pkg::req_t                in_data_i,
  input  ffa_pkg::cmd_t                cmd_i,
  output ffa_pkg::sts_t                sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ffa_pkg::rsp_t                out_data_o
);

  localparam int SW = $clog2(MAX_BLOCKS);
  localparam int AW = ffa_pkg::ADDR_BITS;
  localparam logic [SW:0]   NIL    = (SW+1)'(MAX_BLOCKS);
  localparam logic [AW:0]   HDR    = (AW+1)'(ffa_pkg::HEADER_BYTES);
  localparam logic [SW-1:0] LAST   = SW'(MAX_BLOCKS - 1);

  typedef struct packed {
    logic [AW:0]   start;
    logic [AW-1:0] len;
    logic          free;
    logic [SW:0]   nxt;
    logic [SW:0]   prv;
  } rec_t;

  rec_t mem [MAX_BLOCKS];
  logic [SW-1:0] spare [MAX_BLOCKS];

  logic [ffa_pkg::HEAP_W-1:0] heap_q;
  rec_t          rdata_q, w_q, wr_data;
  logic [SW-1:0] rd_addr, rd_addr_q, w_slot_q, s_q, wr_addr;
  logic [AW:0]   need_q;
  logic [AW-1:0] size_q, off_q;
  logic [SW:0]   cnt_q, wm_q;
  logic [SW-1:0] top_idx, top_idx_q, top_mem_q, top_slot, push_val;
  logic          top_virgin_q;
  logic          out_valid_q;
  ffa_pkg::rsp_t out_q;
  logic [AW:0]   lim, addr_ext;
  logic [AW-1:0] len0, sum;

  // Heap limit saturates at the address space.
  assign lim      = (heap_q > ffa_pkg::HEAP_CAP) ? ffa_pkg::HEAP_CAP : heap_q;
  assign len0     = (lim > HDR) ? AW'(lim - HDR) : '0;
  assign addr_ext = {1'b0, in_data_i.free_addr};
  assign sum      = AW'(w_q.len + rdata_q.len + HDR[AW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= ffa_pkg::HEAP_RESET;
    end else if (cfg_we_i) begin
      heap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      need_q <= {1'b0, in_data_i.alloc_size} + HDR;
      size_q <= in_data_i.alloc_size;
      off_q  <= AW'(addr_ext - HDR);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      ffa_pkg::RD_ZERO:  rd_addr = '0;
      ffa_pkg::RD_RNEXT: rd_addr = rdata_q.nxt[SW-1:0];
      ffa_pkg::RD_WPREV: rd_addr = w_q.prv[SW-1:0];
      ffa_pkg::RD_WNEXT: rd_addr = w_q.nxt[SW-1:0];
      default:           rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_comb begin
    wr_addr = w_slot_q;
    wr_data = w_q;
    case (cmd_i.wr_sel)
      ffa_pkg::WR_INIT: begin
        wr_addr = '0;
        wr_data = '{start: '0, len: len0, free: 1'b1, nxt: NIL, prv: NIL};
      end
      ffa_pkg::WR_SPLIT: begin
        wr_addr = top_slot;
        wr_data = '{start: (AW+1)'(w_q.start + need_q),
                    len:   AW'({1'b0, w_q.len} - need_q),
                    free:  1'b1, nxt: w_q.nxt, prv: {1'b0, w_slot_q}};
      end
      ffa_pkg::WR_AFIT: begin
        wr_data.len  = size_q;
        wr_data.free = 1'b0;
        wr_data.nxt  = {1'b0, s_q};
      end
      ffa_pkg::WR_LINK_S: begin
        wr_addr     = w_q.nxt[SW-1:0];
        wr_data     = rdata_q;
        wr_data.prv = {1'b0, s_q};
      end
      ffa_pkg::WR_LINK_W: begin
        wr_addr     = rd_addr_q;
        wr_data     = rdata_q;
        wr_data.prv = {1'b0, w_slot_q};
      end
      default: begin
        wr_addr = w_slot_q;
        wr_data = w_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.w_ld) begin
      case (cmd_i.w_sel)
        ffa_pkg::W_HIT: begin
          w_q      <= {rdata_q.start, rdata_q.len, 1'b1, rdata_q.nxt, rdata_q.prv};
          w_slot_q <= rd_addr_q;
        end
        ffa_pkg::W_PMERGE: begin
          w_q.start <= rdata_q.start;
          w_q.len   <= sum;
          w_q.prv   <= rdata_q.prv;
          w_slot_q  <= rd_addr_q;
        end
        ffa_pkg::W_NMERGE: begin
          w_q.len <= sum;
          w_q.nxt <= rdata_q.nxt;
        end
        default: begin
          w_q <= w_q;
        end
      endcase
    end
    if (cmd_i.pop) begin
      s_q <= top_slot;
    end
  end

  // Spare-slot stack. Entries below the watermark were never written since
  // the last init and read as their initial contents.
  assign top_idx  = SW'(cnt_q - 1'b1);
  assign top_slot = top_virgin_q ? SW'(LAST - top_idx_q) : top_mem_q;
  assign push_val = cmd_i.push_rd ? rd_addr_q : w_slot_q;

  always_ff @(posedge clk_i) begin
    top_mem_q <= spare[top_idx];
    if (cmd_i.push) begin
      spare[cnt_q[SW-1:0]] <= push_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= (SW+1)'(MAX_BLOCKS - 1);
      wm_q         <= NIL;
      top_idx_q    <= '0;
      top_virgin_q <= 1'b1;
    end else begin
      top_idx_q    <= top_idx;
      top_virgin_q <= ({1'b0, top_idx} < wm_q);
      if (cmd_i.init) begin
        cnt_q <= (SW+1)'(MAX_BLOCKS - 1);
        wm_q  <= NIL;
      end else if (cmd_i.pop) begin
        cnt_q <= cnt_q - 1'b1;
      end else if (cmd_i.push) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q < wm_q) begin
          wm_q <= cnt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_ld) begin
      out_q.status       <= cmd_i.resp_status;
      out_q.payload_addr <= cmd_i.resp_addr ? AW'(w_q.start + HDR) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.fit         = rdata_q.free && ({1'b0, rdata_q.len} >= need_q);
  assign sts_o.match       = (rdata_q.start == {1'b0, off_q});
  assign sts_o.rfree       = rdata_q.free;
  assign sts_o.rnext_nil   = (rdata_q.nxt == NIL);
  assign sts_o.wprev_nil   = (w_q.prv == NIL);
  assign sts_o.wnext_nil   = (w_q.nxt == NIL);
  assign sts_o.spare_empty = (cnt_q == '0);
  assign sts_o.free_bad    = (addr_ext < HDR) || ((addr_ext - HDR) >= lim);
  assign sts_o.req_free    = in_data_i.req_type;
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

endmodule

FILE: src/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing of neighboring free blocks.
// Requests arrive on the in channel (valid/ready); one beat carries either
// an allocate (req_type 0, alloc_size) or a free (req_type 1, free_addr).
// Each request produces exactly one response beat on the out channel with
// a status (ok, out of memory, block store full, free ignored) and, for a
// successful allocate, the payload offset of the new block.
// The block list lives in a single-port-read, single-port-write memory and
// is walked one block per cycle. One request is handled at a time.
// After reset, or after a write of heap_bytes on the config port, the
// block writes the single free block, during which in_ready_o is low.
// The result sits in an output register: a stalled receiver holds the
// result while the next request is already accepted, and the response
// of that request waits in its last state until the register drains.
`include "assert_macros.svh"

module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ffa_pkg::HEAP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ffa_pkg::req_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ffa_pkg::rsp_t              out_data_o
);

  // Commands from the sequencer and status back from the datapath.
  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A request is worked on alone, so the input closes right after a beat.
  `FFA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A spare slot is only taken when the stack holds one.
  `FFA_ASSERT(a_pop_nonempty, clk_i, rst_ni, cmd.pop |-> !sts.spare_empty)
  // The stack is never pushed and popped in the same cycle.
  `FFA_ASSERT(a_one_stack_op, clk_i, rst_ni, !(cmd.pop && cmd.push))

endmodule
